// ===== rtl/fibonacci_by_matrix_power_defines.svh =====
// ----------------------------------------------------------------------------
// fibonacci_by_matrix_power_defines.svh
// Assertion macros used by the checker file of the Fibonacci block.
// ----------------------------------------------------------------------------
`ifndef FIBONACCI_BY_MATRIX_POWER_DEFINES_SVH
`define FIBONACCI_BY_MATRIX_POWER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge.
`define FBMP_ASSERT_IMPLY(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("fbmp assertion failed");

// Next-cycle implication.
`define FBMP_ASSERT_NEXT(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("fbmp assertion failed");

`endif

// ===== rtl/fbmp_pkg.sv =====
// ----------------------------------------------------------------------------
// fbmp_pkg
// Widths, matrix type, constant matrices and entry access helpers.
// ----------------------------------------------------------------------------
package fbmp_pkg;

   localparam int INDEX_BITS = 31;
   localparam int WORD_BITS  = 32;

   // products per 2x2 multiply, and the sequencer count that covers issue,
   // drain and writeback
   localparam int PROD_COUNT = 8;
   localparam int CNT_BITS   = 4;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct packed {
      word_type e00;
      word_type e01;
      word_type e10;
      word_type e11;
   } mat_type;

   localparam mat_type Q_MATRIX = '{
      e00: word_type'(0), e01: word_type'(1),
      e10: word_type'(1), e11: word_type'(1)
   };

   localparam mat_type UNIT_MATRIX = '{
      e00: word_type'(1), e01: word_type'(0),
      e10: word_type'(0), e11: word_type'(1)
   };

   // idx = {row, col}
   function automatic word_type mat_get(mat_type m, logic [1:0] idx);
      word_type r;
      unique case (idx)
         2'b00:   r = m.e00;
         2'b01:   r = m.e01;
         2'b10:   r = m.e10;
         default: r = m.e11;
      endcase
      return r;
   endfunction

   function automatic mat_type mat_put(mat_type m, logic [1:0] idx, word_type v);
      mat_type r;
      r = m;
      unique case (idx)
         2'b00:   r.e00 = v;
         2'b01:   r.e01 = v;
         2'b10:   r.e10 = v;
         default: r.e11 = v;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/fibonacci_by_matrix_power.sv =====
// ----------------------------------------------------------------------------
// fibonacci_by_matrix_power
// F(n) mod 2^WORD_BITS by binary exponentiation of [[0,1],[1,1]].
// ----------------------------------------------------------------------------
//
//   channel   ports                         dir   meaning
//   req       req_valid/req_ready, req_n    in    index n of one item
//   rsp       rsp_valid/rsp_ready,          out   F(n), low 32 bits
//             rsp_fib_value
//
// One shared 32x32 multiplier (low half only) does all the work.
// Each 2x2 product runs 8 issues, then a drain and a writeback.
// Per bit of n: a decide step, the multiply into acc when the bit is set,
// then the square; the loop stops once no set bits remain, and the square
// after the top set bit is skipped.
// Reset clears the sequencer and the output valid; no memories to clear.
// req_ready is high only when idle; a waiting result does not block a new
// item, and a finished item holds in the final state until rsp frees.
//
module fibonacci_by_matrix_power (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [fbmp_pkg::INDEX_BITS-1:0] req_n,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [fbmp_pkg::WORD_BITS-1:0]  rsp_fib_value
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BIT,
      ST_MUL,
      ST_FIN
   } state_type;

   localparam logic [fbmp_pkg::CNT_BITS-1:0] CNT_DRAIN =
      fbmp_pkg::CNT_BITS'(fbmp_pkg::PROD_COUNT);
   localparam logic [fbmp_pkg::CNT_BITS-1:0] CNT_WB =
      fbmp_pkg::CNT_BITS'(fbmp_pkg::PROD_COUNT + 1);

   state_type                         state_ff, state_in;
   fbmp_pkg::mat_type                 acc_ff, acc_in;     // running power product
   fbmp_pkg::mat_type                 pw_ff, pw_in;       // Q^(2^bit)
   fbmp_pkg::mat_type                 res_ff, res_in;     // product being built
   logic [fbmp_pkg::INDEX_BITS-1:0]   n_ff, n_in;         // remaining index bits
   logic [fbmp_pkg::CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic                              to_acc_ff, to_acc_in; // acc*pw, else pw*pw
   fbmp_pkg::word_type                prod_ff, prod_in;
   logic [2:0]                        tag_ff, tag_in;     // {row, col, term}
   logic                              pv_ff, pv_in;       // prod_ff holds a product
   logic                              rsp_valid_ff, rsp_valid_in;
   fbmp_pkg::word_type                value_ff, value_in;

   fbmp_pkg::mat_type                 op_x;
   fbmp_pkg::word_type                a_op, b_op, cur, sum;
   logic [2*fbmp_pkg::WORD_BITS-1:0]  full_prod;

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_fib_value = value_ff;

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      pw_in        = pw_ff;
      res_in       = res_ff;
      n_in         = n_ff;
      cnt_in       = cnt_ff;
      to_acc_in    = to_acc_ff;
      prod_in      = prod_ff;
      tag_in       = tag_ff;
      pv_in        = 1'b0;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      // shared multiplier: product p = cnt[2:0] -> X[row][term] * Y[term][col]
      op_x      = to_acc_ff ? acc_ff : pw_ff;
      a_op      = fbmp_pkg::mat_get(op_x, {cnt_ff[2], cnt_ff[0]});
      b_op      = fbmp_pkg::mat_get(pw_ff, {cnt_ff[0], cnt_ff[1]});
      full_prod = a_op * b_op;

      // accumulate the registered product into its entry
      cur = fbmp_pkg::mat_get(res_ff, tag_ff[2:1]);
      sum = tag_ff[0] ? fbmp_pkg::WORD_BITS'(cur + prod_ff) : prod_ff;
      if (pv_ff) begin
         res_in = fbmp_pkg::mat_put(res_ff, tag_ff[2:1], sum);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               acc_in   = fbmp_pkg::UNIT_MATRIX;
               pw_in    = fbmp_pkg::Q_MATRIX;
               n_in     = req_n;
               state_in = ST_BIT;
            end
         end
         ST_BIT: begin
            if (n_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               to_acc_in = n_ff[0];
               cnt_in    = '0;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            if (cnt_ff < CNT_DRAIN) begin
               prod_in = full_prod[fbmp_pkg::WORD_BITS-1:0];
               tag_in  = cnt_ff[2:0];
               pv_in   = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
            end else if (cnt_ff == CNT_DRAIN) begin
               cnt_in = CNT_WB;
            end else if (to_acc_ff) begin
               acc_in    = res_ff;
               to_acc_in = 1'b0;
               cnt_in    = '0;
               // no higher set bits: further squaring is not needed
               if (n_ff[fbmp_pkg::INDEX_BITS-1:1] == '0) begin
                  state_in = ST_FIN;
               end
            end else begin
               pw_in    = res_ff;
               n_in     = n_ff >> 1;
               state_in = ST_BIT;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               value_in     = acc_ff.e01;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      pw_ff     <= pw_in;
      res_ff    <= res_in;
      n_ff      <= n_in;
      to_acc_ff <= to_acc_in;
      prod_ff   <= prod_in;
      tag_ff    <= tag_in;
      value_ff  <= value_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/fbmp_checker.sv =====
// ----------------------------------------------------------------------------
// fbmp_checker
// Port-level checks on the Fibonacci block, bound to the top level.
// ----------------------------------------------------------------------------
`include "fibonacci_by_matrix_power_defines.svh"

module fbmp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [fbmp_pkg::INDEX_BITS-1:0] req_n,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [fbmp_pkg::WORD_BITS-1:0]  rsp_fib_value
);

   logic req_fire;
   logic n_is_zero;

   assign req_fire  = req_valid && req_ready;
   assign n_is_zero = (req_n == '0);

   // a stalled result holds
   `FBMP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_fib_value))

   // the block is busy right after taking an item
   `FBMP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_ready)

   // leaving reset: idle, no result pending
   `FBMP_ASSERT_NEXT(a_reset_state, clock, 1'b0, reset, req_ready && !rsp_valid)

   // index zero with a free output: answer 0 once the decide and final states have passed
   `FBMP_ASSERT_NEXT(a_zero_index, clock, reset, req_fire && n_is_zero && !rsp_valid, ##2 (rsp_valid && rsp_fib_value == '0))

endmodule

bind fibonacci_by_matrix_power fbmp_checker u_fbmp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_n         (req_n),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_fib_value (rsp_fib_value)
);

// ===== tb/sv/fibonacci_by_matrix_power_tb.sv =====
// ----------------------------------------------------------------------------
// fibonacci_by_matrix_power_tb
// Self-checking bench for the matrix-power Fibonacci block: a short table of
// indexes, then random indexes, scored against known values or an in-bench model.
// ----------------------------------------------------------------------------
module fibonacci_by_matrix_power_tb;

   typedef logic [fbmp_pkg::INDEX_BITS-1:0] index_type;
   typedef logic [fbmp_pkg::WORD_BITS-1:0]  word_type;

   // 2x2 matrix of words, row-major
   typedef struct packed {
      word_type m00;
      word_type m01;
      word_type m10;
      word_type m11;
   } fib_mat_type;

   // one row of the directed table; fib is used only when known is set
   typedef struct {
      index_type n;
      bit        known;
      word_type  fib;
   } fib_case_type;

   localparam int CASE_COUNT   = 16;
   localparam int RANDOM_ITEMS = 1155;
   // receiver hold-off, long enough for the block to fill and drop req_ready
   localparam int HOLD_CYCLES  = 1500;
   localparam int HOLD_AT_ITEM = 300;
   // stretch of random items with no idling on either side
   localparam int QUIET_FIRST  = 500;
   localparam int QUIET_LAST   = 699;
   // drain wait after the last result, longer than the worst item
   localparam int TAIL_CYCLES  = 700;
   // cycles with no item moving on either channel before giving up
   localparam int STALL_LIMIT  = 8000;

   logic      clock     = 1'b0;
   logic      reset     = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   index_type req_n     = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   word_type  rsp_fib_value;

   // expected F(n) values, oldest first
   word_type fib_due_q [$];
   int       mismatch_count = 0;
   bit       quiet          = 1'b0;
   bit       hold_off_req   = 1'b0;

   always #2 clock = ~clock;

   fibonacci_by_matrix_power dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_n         (req_n),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_fib_value (rsp_fib_value)
   );

   // -------------------------------------------------------------------------
   // Model: Q = [[0,1],[1,1]] raised to n by square-and-multiply, all sums and
   // products truncated to the word width. F(n) is the top-right entry.
   // -------------------------------------------------------------------------
   function automatic fib_mat_type mat_times(fib_mat_type x, fib_mat_type y);
      fib_mat_type r;
      r.m00 = x.m00 * y.m00 + x.m01 * y.m10;
      r.m01 = x.m00 * y.m01 + x.m01 * y.m11;
      r.m10 = x.m10 * y.m00 + x.m11 * y.m10;
      r.m11 = x.m10 * y.m01 + x.m11 * y.m11;
      return r;
   endfunction

   function automatic word_type fib_mod_word(index_type n);
      fib_mat_type acc;
      fib_mat_type pw;
      acc = '{m00: word_type'(1), m01: word_type'(0),
              m10: word_type'(0), m11: word_type'(1)};
      pw  = '{m00: word_type'(0), m01: word_type'(1),
              m10: word_type'(1), m11: word_type'(1)};
      for (int b = 0; b < fbmp_pkg::INDEX_BITS; b++) begin
         if (n[b]) begin
            acc = mat_times(acc, pw);
         end
         pw = mat_times(pw, pw);
      end
      return acc.m01;
   endfunction

   // Random index. Run time grows with the top set bit, so most indexes are
   // short; a share use the full width so every bit sees both values.
   function automatic index_type pick_index();
      index_type n;
      int        w;
      case ($urandom_range(9))
         6: begin
            // single bit at any position, or a solid run of ones from bit 0
            w = $urandom_range(fbmp_pkg::INDEX_BITS - 1);
            n = $urandom_range(1) ? (index_type'(1) << w) : ~(index_type'(0)) >> w;
         end
         7, 8, 9: begin
            n = index_type'($urandom);
         end
         default: begin
            w = $urandom_range(10, 1);
            n = index_type'($urandom) & ((index_type'(1) << w) - index_type'(1));
         end
      endcase
      return n;
   endfunction

   // Directed table: zero index, small values, the last F(n) that fits in
   // 32 bits and the first that wraps, plus extremes of the index field.
   fib_case_type dir_cases [CASE_COUNT] = '{
      '{index_type'(0),            1'b1, word_type'(0)},
      '{index_type'(1),            1'b1, word_type'(1)},
      '{index_type'(2),            1'b1, word_type'(1)},
      '{index_type'(3),            1'b1, word_type'(2)},
      '{index_type'(10),           1'b1, word_type'(55)},
      '{index_type'(47),           1'b1, word_type'(32'd2971215073)},
      '{index_type'(48),           1'b1, word_type'(32'd512559680)},
      '{index_type'(93),           1'b0, word_type'(0)},
      '{index_type'(1000),         1'b0, word_type'(0)},
      '{index_type'(31'h7FFFFFFF), 1'b0, word_type'(0)},
      '{index_type'(31'h7FFFFFFE), 1'b0, word_type'(0)},
      '{index_type'(31'h40000000), 1'b0, word_type'(0)},
      '{index_type'(31'h55555555), 1'b0, word_type'(0)},
      '{index_type'(31'h2AAAAAAA), 1'b0, word_type'(0)},
      '{index_type'(31'h00010000), 1'b0, word_type'(0)},
      '{index_type'(0),            1'b1, word_type'(0)}
   };

   // -------------------------------------------------------------------------
   // Sender. Valid stays up across back-to-back items; only idle gaps drop it.
   // The expectation is queued at the edge the item is taken.
   // -------------------------------------------------------------------------
   task automatic offer_index(index_type n, word_type due);
      while (!quiet && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_n     <= n;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      fib_due_q.push_back(due);
   endtask

   initial begin
      index_type n;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < CASE_COUNT; i++) begin
         n = dir_cases[i].n;
         offer_index(n, dir_cases[i].known ? dir_cases[i].fib : fib_mod_word(n));
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         quiet = (i >= QUIET_FIRST && i <= QUIET_LAST);
         // stall the result side once; sender keeps pushing meanwhile
         if (i == HOLD_AT_ITEM) begin
            hold_off_req = 1'b1;
         end
         n = pick_index();
         offer_index(n, fib_mod_word(n));
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      // drain, then give the block time to show any stray result
      while (fib_due_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("fibonacci_by_matrix_power: match");
      end else begin
         $display("fibonacci_by_matrix_power: mismatch");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // Receiver: random ready, a quiet stretch, and one long hold-off.
   // -------------------------------------------------------------------------
   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= quiet || ($urandom_range(99) >= 6);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result checker. Signals are read right after the edge, so they hold
   // the values the edge itself saw.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         if (fib_due_q.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual fib_value %0d",
                     $time, rsp_fib_value);
            mismatch_count++;
         end else if (rsp_fib_value !== fib_due_q[0]) begin
            $display("%0t: fib_value expected %0d, actual %0d",
                     $time, fib_due_q[0], rsp_fib_value);
            mismatch_count++;
            void'(fib_due_q.pop_front());
         end else begin
            void'(fib_due_q.pop_front());
         end
      end
   end

   // Watchdog: nothing moving on either channel for too long ends the run.
   initial begin
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("%0t: timeout, %0d items still expected", $time, fib_due_q.size());
      $display("fibonacci_by_matrix_power: mismatch");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/fbmp_pkg.sv
rtl/fibonacci_by_matrix_power.sv
rtl/fbmp_checker.sv
tb/sv/fibonacci_by_matrix_power_tb.sv
